// ----- rtl/nbgm_pkg.sv -----
// Shared codes and constants for the gravity merge/integrate block.
// No dependencies; imported by every module of the block.
package nbgm_pkg;

  // Item kinds on the input channel
  localparam logic [2:0] KIND_LOAD  = 3'd0;
  localparam logic [2:0] KIND_CLEAR = 3'd1;
  localparam logic [2:0] KIND_PAIR  = 3'd2;
  localparam logic [2:0] KIND_POINT = 3'd3;
  localparam logic [2:0] KIND_MOVE  = 3'd4;

  // Result event codes
  localparam logic [1:0] EV_REPORT   = 2'd0;
  localparam logic [1:0] EV_ABSORB   = 2'd1;
  localparam logic [1:0] EV_ABSORBED = 2'd2;
  localparam logic [1:0] EV_SKIP     = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_GRAV  = 2'd0;
  localparam logic [1:0] CFG_SOFT  = 2'd1;
  localparam logic [1:0] CFG_MERGE = 2'd2;

  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;
  localparam logic [46:0] CAP47   = '1;

endpackage

// ----- rtl/nbgm_div.sv -----
// Iterative restoring divider, one quotient bit per cycle, quotient capped at 2^47-1.
// Depends on nbgm_pkg.
module nbgm_div import nbgm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [32:0] den_i,
  output logic        done_o,
  output logic [46:0] quo_o
);

  localparam int unsigned Steps = 48;
  localparam logic [5:0] LastStep = 6'(Steps - 1);

  logic        busy_q, done_q, sat_q;
  logic [5:0]  cnt_q;
  logic [32:0] rem_q, den_q;
  logic [47:0] sh_q;
  logic [33:0] trial, diff;
  logic        ge;

  // Trial subtract of the next partial remainder
  assign trial = {rem_q, sh_q[47]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      sat_q  <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
      sh_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        den_q <= den_i;
        cnt_q <= '0;
        // Quotient of 2^47 or more saturates at once
        if ({16'b0, num_i[63:47]} >= den_i) begin
          sat_q  <= 1'b1;
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          sat_q  <= 1'b0;
          busy_q <= 1'b1;
          rem_q  <= {17'b0, num_i[63:48]};
          sh_q   <= num_i[47:0];
        end
      end else if (busy_q) begin
        rem_q <= ge ? diff[32:0] : trial[32:0];
        sh_q  <= {sh_q[46:0], ge};
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == LastStep) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = sat_q ? CAP47 : sh_q[46:0];

endmodule

// ----- rtl/nbgm_sqrt.sv -----
// Iterative integer square root of a 64-bit radicand, one root bit per cycle.
// Depends on nbgm_pkg.
module nbgm_sqrt import nbgm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] rad_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  localparam logic [4:0] LastStep = 5'd31;

  logic        busy_q, done_q;
  logic [4:0]  cnt_q;
  logic [32:0] rem_q;
  logic [31:0] root_q;
  logic [63:0] x_q;
  logic [34:0] remn, trial, diff;
  logic        ge;

  // Bring down two radicand bits and try root*4+1
  assign remn  = {rem_q, x_q[63:62]};
  assign trial = {1'b0, root_q, 2'b01};
  assign ge    = remn >= trial;
  assign diff  = remn - trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      root_q <= '0;
      x_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        rem_q  <= '0;
        root_q <= '0;
        x_q    <= rad_i;
      end else if (busy_q) begin
        rem_q  <= ge ? diff[32:0] : remn[32:0];
        root_q <= {root_q[30:0], ge};
        x_q    <= {x_q[61:0], 2'b00};
        cnt_q  <= cnt_q + 5'd1;
        if (cnt_q == LastStep) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ----- rtl/nbody_gravity_merge_integrate.sv -----
// From the accepting edge, load, clear, skipped pair and unknown kinds go straight to the output
// register; a move, a merging pair and a force pair first run their steps, and a force pair at
// zero distance skips its divides; each divide that saturates at once ends early, and a stalled
// output register adds its wait. Items are taken one at a time, through divider and square root.
// A new item is taken while the previous result still waits in the output register.
// Reset (async, active low) clears the body, force sums, output valid; config to 1.0.
// Depends on nbgm_pkg, nbgm_div and nbgm_sqrt.
module nbody_gravity_merge_integrate import nbgm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         kind_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [31:0] vel_x_i,
  input  logic signed [31:0] vel_y_i,
  input  logic signed [31:0] vel_z_i,
  input  logic [31:0]        body_mass_i,
  input  logic               other_alive_i,
  input  logic [31:0]        time_step_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         event_res_o,
  output logic signed [31:0] out_pos_x_o,
  output logic signed [31:0] out_pos_y_o,
  output logic signed [31:0] out_pos_z_o,
  output logic signed [31:0] out_vel_x_o,
  output logic signed [31:0] out_vel_y_o,
  output logic signed [31:0] out_vel_z_o,
  output logic [31:0]        out_mass_o,
  output logic               target_alive_o
);

  typedef enum logic [29:0] {
    ST_IDLE      = 30'd1 << 0,
    ST_DELTA     = 30'd1 << 1,
    ST_SQMUL     = 30'd1 << 2,
    ST_SQACC     = 30'd1 << 3,
    ST_SQ_GO     = 30'd1 << 4,
    ST_SQ_WAIT   = 30'd1 << 5,
    ST_AFT_SOFT  = 30'd1 << 6,
    ST_AFT_PLAIN = 30'd1 << 7,
    ST_GM_MUL    = 30'd1 << 8,
    ST_GM_SHIFT  = 30'd1 << 9,
    ST_Q1        = 30'd1 << 10,
    ST_Q2        = 30'd1 << 11,
    ST_FQ        = 30'd1 << 12,
    ST_UAX       = 30'd1 << 13,
    ST_UC        = 30'd1 << 14,
    ST_FACC      = 30'd1 << 15,
    ST_MMUL      = 30'd1 << 16,
    ST_MDIV      = 30'd1 << 17,
    ST_MVEL      = 30'd1 << 18,
    ST_MFIN      = 30'd1 << 19,
    ST_MA        = 30'd1 << 20,
    ST_MDV       = 30'd1 << 21,
    ST_MVV       = 30'd1 << 22,
    ST_MPP       = 30'd1 << 23,
    ST_UM_HI     = 30'd1 << 24,
    ST_UM_LO     = 30'd1 << 25,
    ST_UM_FIN    = 30'd1 << 26,
    ST_DV_GO     = 30'd1 << 27,
    ST_DV_WAIT   = 30'd1 << 28,
    ST_DONE      = 30'd1 << 29
  } state_e;

  // Signed add of a magnitude, saturated to 32 bits
  function automatic logic [31:0] add_sat32(input logic [31:0] v, input logic [46:0] mag,
                                            input logic neg);
    logic [48:0] s;
    s = {{17{v[31]}}, v} + (neg ? (49'd0 - {2'b0, mag}) : {2'b0, mag});
    if (!s[48] && (s[47:31] != '0))      add_sat32 = 32'h7FFF_FFFF;
    else if (s[48] && (s[47:31] != '1))  add_sat32 = 32'h8000_0000;
    else                                 add_sat32 = s[31:0];
  endfunction

  // Signed add of a magnitude, saturated to 48 bits
  function automatic logic [47:0] add_sat48(input logic [47:0] f, input logic [46:0] mag,
                                            input logic neg);
    logic [48:0] s;
    s = {f[47], f} + (neg ? (49'd0 - {2'b0, mag}) : {2'b0, mag});
    if (s[48:47] == 2'b01)      add_sat48 = {1'b0, CAP47};
    else if (s[48:47] == 2'b10) add_sat48 = {1'b1, 47'd0};
    else                        add_sat48 = s[47:0];
  endfunction

  state_e st_q, ret_q;
  logic [1:0]  ax_q;

  logic [31:0] grav_q, soft_len_q, merge_q;

  logic [31:0] pos_q [3];
  logic [31:0] vel_q [3];
  logic [47:0] force_q [3];
  logic [31:0] mass_q;
  logic        live_q;

  logic [2:0]  kind_q;
  logic [31:0] in_pos_q [3];
  logic [31:0] in_vel_q [3];
  logic [31:0] in_mass_q, dt_q;

  logic [32:0] d_q [3];
  logic [63:0] acc_q, sp_q, sq_in_q;
  logic [32:0] soft_q, plain_q, msum_q;
  logic [46:0] f_q, um_r_q;
  logic [47:0] um_a_q;
  logic [31:0] um_b_q;
  logic [63:0] hi_q, prod_q;
  logic [63:0] dv_n_q;
  logic [32:0] dv_d_q;
  logic [1:0]  ev_q;
  logic [31:0] ovel_q [3];
  logic [31:0] omass_q;

  logic        out_valid_q;
  logic [1:0]  out_ev_q;
  logic [31:0] out_pos_q [3];
  logic [31:0] out_vel_q [3];
  logic [31:0] out_mass_q;
  logic        out_live_q;

  logic        in_fire;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod_d, acc_nx;
  logic [32:0] cur_d, cur_vd;
  logic [31:0] cur_dmag, cur_vdmag, cur_pos, cur_vel, cur_invel;
  logic [47:0] cur_force, fmag;
  logic [47:0] um_sum;
  logic [46:0] um_res;
  logic [16:0] u17;
  logic [31:0] t_mrg, vnew, vnew_mag;
  logic [32:0] ovel_nx;
  logic        sq_done, dv_done;
  logic [31:0] sq_root;
  logic [46:0] dv_quo;
  logic [32:0] soft_nx;

  assign in_fire    = in_valid_i && (st_q == ST_IDLE);
  assign in_stall_o = (st_q != ST_IDLE);

  // Select the current axis operands
  always_comb begin
    case (ax_q)
      2'd0: begin
        cur_d = d_q[0]; cur_pos = pos_q[0]; cur_vel = vel_q[0];
        cur_invel = in_vel_q[0]; cur_force = force_q[0];
      end
      2'd1: begin
        cur_d = d_q[1]; cur_pos = pos_q[1]; cur_vel = vel_q[1];
        cur_invel = in_vel_q[1]; cur_force = force_q[1];
      end
      default: begin
        cur_d = d_q[2]; cur_pos = pos_q[2]; cur_vel = vel_q[2];
        cur_invel = in_vel_q[2]; cur_force = force_q[2];
      end
    endcase
  end

  logic [32:0] neg_d, neg_vd;
  assign neg_d     = 33'd0 - cur_d;
  assign cur_dmag  = cur_d[32] ? neg_d[31:0] : cur_d[31:0];
  assign cur_vd    = {cur_vel[31], cur_vel} - {cur_invel[31], cur_invel};
  assign neg_vd    = 33'd0 - cur_vd;
  assign cur_vdmag = cur_vd[32] ? neg_vd[31:0] : cur_vd[31:0];
  assign fmag      = cur_force[47] ? (48'd0 - cur_force) : cur_force;

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (st_q)
      ST_SQMUL: begin
        mul_a = (ax_q == 2'd3) ? soft_len_q : cur_dmag;
        mul_b = mul_a;
      end
      ST_GM_MUL: begin
        mul_a = grav_q;
        mul_b = mass_q;
      end
      ST_UM_HI: begin
        mul_a = um_a_q[47:16];
        mul_b = um_b_q;
      end
      ST_UM_LO: begin
        mul_a = {16'b0, um_a_q[15:0]};
        mul_b = um_b_q;
      end
      ST_MMUL: begin
        mul_a = cur_vdmag;
        mul_b = mass_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;
  assign acc_nx = acc_q + {2'b00, prod_q[63:2]};

  // Finish a Q16 product: high part plus low part, capped at 2^47-1
  assign um_sum = {1'b0, hi_q[46:0]} + {16'b0, prod_q[47:16]};
  assign um_res = (hi_q[63:47] != '0 || um_sum[47]) ? CAP47 : um_sum[46:0];

  assign u17      = (dv_quo > 47'(ONE_Q16)) ? ONE_Q16[16:0] : dv_quo[16:0];
  assign t_mrg    = (msum_q == '0) ? 32'd0 : dv_quo[31:0];
  assign ovel_nx  = {cur_invel[31], cur_invel} +
                    (cur_vd[32] ? (33'd0 - {1'b0, t_mrg}) : {1'b0, t_mrg});
  assign vnew     = add_sat32(cur_vel, um_r_q, cur_force[47]);
  assign vnew_mag = vnew[31] ? (32'd0 - vnew) : vnew;
  assign soft_nx  = {sq_root, 1'b0};

  nbgm_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (st_q == ST_SQ_GO),
    .rad_i   (sq_in_q),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  nbgm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (st_q == ST_DV_GO),
    .num_i   (dv_n_q),
    .den_i   (dv_d_q),
    .done_o  (dv_done),
    .quo_o   (dv_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      ret_q       <= ST_IDLE;
      ax_q        <= '0;
      grav_q      <= ONE_Q16;
      soft_len_q  <= ONE_Q16;
      merge_q     <= ONE_Q16;
      mass_q      <= '0;
      live_q      <= 1'b0;
      kind_q      <= '0;
      in_mass_q   <= '0;
      dt_q        <= '0;
      acc_q       <= '0;
      sp_q        <= '0;
      sq_in_q     <= '0;
      soft_q      <= '0;
      plain_q     <= '0;
      msum_q      <= '0;
      f_q         <= '0;
      um_r_q      <= '0;
      um_a_q      <= '0;
      um_b_q      <= '0;
      hi_q        <= '0;
      prod_q      <= '0;
      dv_n_q      <= '0;
      dv_d_q      <= '0;
      ev_q        <= EV_REPORT;
      omass_q     <= '0;
      out_valid_q <= 1'b0;
      out_ev_q    <= EV_REPORT;
      out_mass_q  <= '0;
      out_live_q  <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        pos_q[i]     <= '0;
        vel_q[i]     <= '0;
        force_q[i]   <= '0;
        in_pos_q[i]  <= '0;
        in_vel_q[i]  <= '0;
        d_q[i]       <= '0;
        ovel_q[i]    <= '0;
        out_pos_q[i] <= '0;
        out_vel_q[i] <= '0;
      end
    end else begin
      prod_q <= prod_d;

      // Configuration writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_GRAV:  grav_q     <= cfg_data_i;
          CFG_SOFT:  soft_len_q <= cfg_data_i;
          CFG_MERGE: merge_q    <= cfg_data_i;
          default:   ;
        endcase
      end

      // Drop the output once it transfers, unless a new result replaces it
      if (out_valid_q && !out_stall_i && (st_q != ST_DONE)) out_valid_q <= 1'b0;

      case (st_q)
        ST_IDLE: begin
          if (in_fire) begin
            kind_q      <= kind_i;
            in_pos_q[0] <= pos_x_i;
            in_pos_q[1] <= pos_y_i;
            in_pos_q[2] <= pos_z_i;
            in_vel_q[0] <= vel_x_i;
            in_vel_q[1] <= vel_y_i;
            in_vel_q[2] <= vel_z_i;
            in_mass_q   <= body_mass_i;
            dt_q        <= time_step_i;
            ev_q        <= EV_REPORT;
            ax_q        <= '0;
            case (kind_i)
              KIND_LOAD: begin
                pos_q[0] <= pos_x_i;
                pos_q[1] <= pos_y_i;
                pos_q[2] <= pos_z_i;
                vel_q[0] <= vel_x_i;
                vel_q[1] <= vel_y_i;
                vel_q[2] <= vel_z_i;
                for (int i = 0; i < 3; i++) force_q[i] <= '0;
                mass_q <= body_mass_i;
                live_q <= 1'b1;
                st_q   <= ST_DONE;
              end
              KIND_CLEAR: begin
                for (int i = 0; i < 3; i++) force_q[i] <= '0;
                st_q <= ST_DONE;
              end
              KIND_PAIR: begin
                if (!live_q || !other_alive_i) begin
                  ev_q <= EV_SKIP;
                  st_q <= ST_DONE;
                end else begin
                  st_q <= ST_DELTA;
                end
              end
              KIND_POINT: st_q <= ST_DELTA;
              KIND_MOVE:  st_q <= (mass_q == '0) ? ST_DONE : ST_MA;
              default:    st_q <= ST_DONE;
            endcase
          end
        end

        // Deltas from the target to the other body
        ST_DELTA: begin
          for (int i = 0; i < 3; i++)
            d_q[i] <= {in_pos_q[i][31], in_pos_q[i]} - {pos_q[i][31], pos_q[i]};
          acc_q <= '0;
          ax_q  <= '0;
          st_q  <= ST_SQMUL;
        end

        ST_SQMUL: st_q <= ST_SQACC;

        // Accumulate quarter squares; the fourth pass adds the softening
        ST_SQACC: begin
          acc_q <= acc_nx;
          if (ax_q == 2'd2) sp_q <= acc_nx;
          if (ax_q == 2'd3) begin
            sq_in_q <= acc_nx;
            ret_q   <= ST_AFT_SOFT;
            st_q    <= ST_SQ_GO;
          end else begin
            ax_q <= ax_q + 2'd1;
            st_q <= ST_SQMUL;
          end
        end

        ST_SQ_GO: st_q <= ST_SQ_WAIT;
        ST_SQ_WAIT: if (sq_done) st_q <= ret_q;

        ST_AFT_SOFT: begin
          soft_q <= soft_nx;
          if (kind_q == KIND_PAIR && soft_nx < {1'b0, merge_q}) begin
            msum_q <= {1'b0, mass_q} + {1'b0, in_mass_q};
            ax_q   <= '0;
            st_q   <= ST_MMUL;
          end else begin
            sq_in_q <= sp_q;
            ret_q   <= ST_AFT_PLAIN;
            st_q    <= ST_SQ_GO;
          end
        end

        ST_AFT_PLAIN: begin
          plain_q <= soft_nx;
          st_q    <= (sq_root == '0) ? ST_DONE : ST_GM_MUL;
        end

        ST_GM_MUL: st_q <= ST_GM_SHIFT;

        ST_GM_SHIFT: begin
          um_a_q <= prod_q[63:16];
          um_b_q <= in_mass_q;
          ret_q  <= ST_Q1;
          st_q   <= ST_UM_HI;
        end

        // Q16 product subroutine
        ST_UM_HI: st_q <= ST_UM_LO;
        ST_UM_LO: begin
          hi_q <= prod_q;
          st_q <= ST_UM_FIN;
        end
        ST_UM_FIN: begin
          um_r_q <= um_res;
          st_q   <= ret_q;
        end

        // Divide subroutine
        ST_DV_GO: st_q <= ST_DV_WAIT;
        ST_DV_WAIT: if (dv_done) st_q <= ret_q;

        ST_Q1: begin
          dv_n_q <= {1'b0, um_r_q, 16'b0};
          dv_d_q <= soft_q;
          ret_q  <= ST_Q2;
          st_q   <= ST_DV_GO;
        end

        ST_Q2: begin
          dv_n_q <= {1'b0, dv_quo, 16'b0};
          dv_d_q <= soft_q;
          ret_q  <= ST_FQ;
          st_q   <= ST_DV_GO;
        end

        ST_FQ: begin
          f_q  <= dv_quo;
          ax_q <= '0;
          st_q <= ST_UAX;
        end

        // Unit direction component of this axis
        ST_UAX: begin
          dv_n_q <= {16'b0, cur_dmag, 16'b0};
          dv_d_q <= plain_q;
          ret_q  <= ST_UC;
          st_q   <= ST_DV_GO;
        end

        ST_UC: begin
          um_a_q <= {1'b0, f_q};
          um_b_q <= {15'b0, u17};
          ret_q  <= ST_FACC;
          st_q   <= ST_UM_HI;
        end

        ST_FACC: begin
          force_q[ax_q] <= add_sat48(cur_force, um_r_q, cur_d[32]);
          if (ax_q == 2'd2) begin
            st_q <= ST_DONE;
          end else begin
            ax_q <= ax_q + 2'd1;
            st_q <= ST_UAX;
          end
        end

        // Mass-weighted merge velocity, one axis at a time
        ST_MMUL: st_q <= ST_MDIV;

        ST_MDIV: begin
          dv_n_q <= prod_q;
          dv_d_q <= msum_q;
          ret_q  <= ST_MVEL;
          st_q   <= ST_DV_GO;
        end

        ST_MVEL: begin
          ovel_q[ax_q] <= ovel_nx[31:0];
          if (ax_q == 2'd2) begin
            st_q <= ST_MFIN;
          end else begin
            ax_q <= ax_q + 2'd1;
            st_q <= ST_MMUL;
          end
        end

        ST_MFIN: begin
          omass_q <= msum_q[32] ? 32'hFFFF_FFFF : msum_q[31:0];
          if (mass_q > in_mass_q) begin
            ev_q <= EV_ABSORB;
            for (int i = 0; i < 3; i++) vel_q[i] <= ovel_q[i];
            mass_q <= msum_q[32] ? 32'hFFFF_FFFF : msum_q[31:0];
          end else begin
            ev_q   <= EV_ABSORBED;
            live_q <= 1'b0;
            mass_q <= '0;
          end
          st_q <= ST_DONE;
        end

        // Euler step: acceleration, velocity, then position
        ST_MA: begin
          dv_n_q <= {fmag, 16'b0};
          dv_d_q <= {1'b0, mass_q};
          ret_q  <= ST_MDV;
          st_q   <= ST_DV_GO;
        end

        ST_MDV: begin
          um_a_q <= {1'b0, dv_quo};
          um_b_q <= dt_q;
          ret_q  <= ST_MVV;
          st_q   <= ST_UM_HI;
        end

        ST_MVV: begin
          vel_q[ax_q] <= vnew;
          um_a_q      <= {16'b0, vnew_mag};
          um_b_q      <= dt_q;
          ret_q       <= ST_MPP;
          st_q        <= ST_UM_HI;
        end

        ST_MPP: begin
          pos_q[ax_q] <= add_sat32(cur_pos, um_r_q, cur_vel[31]);
          if (ax_q == 2'd2) begin
            st_q <= ST_DONE;
          end else begin
            ax_q <= ax_q + 2'd1;
            st_q <= ST_MA;
          end
        end

        // Hold until the output register is free, then load it
        ST_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            out_ev_q    <= ev_q;
            for (int i = 0; i < 3; i++) begin
              out_pos_q[i] <= pos_q[i];
              out_vel_q[i] <= (ev_q == EV_ABSORBED) ? ovel_q[i] : vel_q[i];
            end
            out_mass_q <= (ev_q == EV_ABSORBED) ? omass_q : mass_q;
            out_live_q <= live_q;
            st_q       <= ST_IDLE;
          end
        end

        default: st_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign event_res_o    = out_ev_q;
  assign out_pos_x_o    = out_pos_q[0];
  assign out_pos_y_o    = out_pos_q[1];
  assign out_pos_z_o    = out_pos_q[2];
  assign out_vel_x_o    = out_vel_q[0];
  assign out_vel_y_o    = out_vel_q[1];
  assign out_vel_z_o    = out_vel_q[2];
  assign out_mass_o     = out_mass_q;
  assign target_alive_o = out_live_q;

endmodule

// ----- tb/sv/nbgm_checker.sv -----
// Checker for the gravity merge/integrate block: predicts each result from the
// accepted transfers and compares it field by field. Depends on nbgm_pkg.
module nbgm_checker import nbgm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_stall_o,
  input  logic [2:0]         kind_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [31:0] vel_x_i,
  input  logic signed [31:0] vel_y_i,
  input  logic signed [31:0] vel_z_i,
  input  logic [31:0]        body_mass_i,
  input  logic               other_alive_i,
  input  logic [31:0]        time_step_i,
  input  logic               out_valid_o,
  input  logic               out_stall_i,
  input  logic [1:0]         event_res_o,
  input  logic signed [31:0] out_pos_x_o,
  input  logic signed [31:0] out_pos_y_o,
  input  logic signed [31:0] out_pos_z_o,
  input  logic signed [31:0] out_vel_x_o,
  input  logic signed [31:0] out_vel_y_o,
  input  logic signed [31:0] out_vel_z_o,
  input  logic [31:0]        out_mass_o,
  input  logic               target_alive_o,
  output int                 errors_o,
  output int                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned SAT47 = 64'h0000_7FFF_FFFF_FFFF;
  localparam longint unsigned MASK32 = 64'h0000_0000_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]  ev;
    logic [31:0] px, py, pz, vx, vy, vz, mass;
    logic        alive;
  } body_report_t;

  body_report_t report_q[$];

  // Shadow of the target body and the registers
  longint          body_pos[3];
  longint          body_vel[3];
  longint          force_acc[3];
  longint unsigned body_mass;
  bit              body_live;
  longint unsigned grav_reg, soft_reg, merge_reg;

  function automatic longint unsigned abs64(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // floor(a*b/2^16), capped at 2^47-1
  function automatic longint unsigned mul_q16_cap(longint unsigned a, longint unsigned b);
    longint unsigned hi, lo;
    hi = (a >> 16) * b;
    lo = ((a & 64'hFFFF) * b) >> 16;
    if (hi > SAT47) return SAT47;
    hi += lo;
    return hi > SAT47 ? SAT47 : hi;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // Advance the shadow body by one transfer and return the report it yields
  function automatic body_report_t step_body(logic [2:0] kind, longint op[3], longint ov[3],
                                             longint unsigned m2, bit o_alive,
                                             longint unsigned dt);
    body_report_t r;
    longint d[3], new_vel[3], f;
    longint unsigned sq, plain, soft_dist, gmm, q, u, c, msum, t, merged, acc, dv;
    logic [1:0] ev;
    ev = EV_REPORT;
    merged = 0;
    for (int i = 0; i < 3; i++) new_vel[i] = 0;
    case (kind)
      KIND_LOAD: begin
        for (int i = 0; i < 3; i++) begin
          body_pos[i] = op[i];
          body_vel[i] = ov[i];
          force_acc[i] = 0;
        end
        body_mass = m2;
        body_live = 1'b1;
      end
      KIND_CLEAR: for (int i = 0; i < 3; i++) force_acc[i] = 0;
      KIND_PAIR, KIND_POINT: begin
        if (kind == KIND_PAIR && (!body_live || !o_alive)) begin
          ev = EV_SKIP;
        end else begin
          sq = 0;
          for (int i = 0; i < 3; i++) begin
            d[i] = op[i] - body_pos[i];
            sq += (abs64(d[i]) * abs64(d[i])) >> 2;
          end
          plain = int_sqrt(sq) << 1;
          soft_dist = int_sqrt(sq + ((soft_reg * soft_reg) >> 2)) << 1;
          if (kind == KIND_PAIR && soft_dist < merge_reg) begin
            // merge: mass-weighted velocity, heavier body absorbs
            msum = body_mass + m2;
            for (int i = 0; i < 3; i++) begin
              f = body_vel[i] - ov[i];
              t = msum != 0 ? (abs64(f) * body_mass) / msum : 0;
              new_vel[i] = ov[i] + (f < 0 ? -longint'(t) : longint'(t));
            end
            merged = msum > MASK32 ? MASK32 : msum;
            if (body_mass > m2) begin
              ev = EV_ABSORB;
              for (int i = 0; i < 3; i++) body_vel[i] = new_vel[i];
              body_mass = merged;
            end else begin
              ev = EV_ABSORBED;
              body_live = 1'b0;
              body_mass = 0;
            end
          end else if (soft_dist != 0 && plain != 0) begin
            gmm = mul_q16_cap((grav_reg * body_mass) >> 16, m2);
            q = (gmm << 16) / soft_dist;
            if (q > SAT47) q = SAT47;
            q = (q << 16) / soft_dist;
            if (q > SAT47) q = SAT47;
            for (int i = 0; i < 3; i++) begin
              u = (abs64(d[i]) << 16) / plain;
              if (u > 64'h10000) u = 64'h10000;
              c = (q * u) >> 16;
              f = force_acc[i] + (d[i] < 0 ? -longint'(c) : longint'(c));
              if (f > longint'(SAT47)) f = SAT47;
              if (f < -longint'(SAT47) - 1) f = -longint'(SAT47) - 1;
              force_acc[i] = f;
            end
          end
        end
      end
      KIND_MOVE: begin
        if (body_mass != 0) begin
          for (int i = 0; i < 3; i++) begin
            acc = (abs64(force_acc[i]) << 16) / body_mass;
            if (acc > SAT47) acc = SAT47;
            dv = mul_q16_cap(acc, dt);
            body_vel[i] = clip32(body_vel[i] + (force_acc[i] < 0 ? -longint'(dv) : longint'(dv)));
            dv = mul_q16_cap(abs64(body_vel[i]), dt);
            body_pos[i] = clip32(body_pos[i] +
                                 (body_vel[i] < 0 ? -longint'(dv) : longint'(dv)));
          end
        end
      end
      default: ;
    endcase
    r.ev = ev;
    r.px = body_pos[0][31:0];
    r.py = body_pos[1][31:0];
    r.pz = body_pos[2][31:0];
    r.vx = ev == EV_ABSORBED ? new_vel[0][31:0] : body_vel[0][31:0];
    r.vy = ev == EV_ABSORBED ? new_vel[1][31:0] : body_vel[1][31:0];
    r.vz = ev == EV_ABSORBED ? new_vel[2][31:0] : body_vel[2][31:0];
    r.mass = ev == EV_ABSORBED ? merged[31:0] : body_mass[31:0];
    r.alive = body_live;
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      errors_o++;
    end
  endtask

  // Track register writes, predict on input transfers, compare on output transfers
  always @(posedge clk_i or negedge rst_ni) begin
    longint op[3], ov[3];
    body_report_t got, want;
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        body_pos[i] = 0;
        body_vel[i] = 0;
        force_acc[i] = 0;
      end
      body_mass = 0;
      body_live = 1'b0;
      grav_reg = 64'h10000;
      soft_reg = 64'h10000;
      merge_reg = 64'h10000;
      report_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_GRAV:  grav_reg = cfg_data_i;
          CFG_SOFT:  soft_reg = cfg_data_i;
          CFG_MERGE: merge_reg = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_o && !out_stall_i) begin
        got = '{event_res_o, out_pos_x_o, out_pos_y_o, out_pos_z_o, out_vel_x_o,
                out_vel_y_o, out_vel_z_o, out_mass_o, target_alive_o};
        if (report_q.size() == 0) begin
          $error("result transfer with no expected result");
          errors_o++;
        end else begin
          want = report_q.pop_front();
          check_field("event_res", 32'(want.ev), 32'(got.ev));
          check_field("out_pos_x", want.px, got.px);
          check_field("out_pos_y", want.py, got.py);
          check_field("out_pos_z", want.pz, got.pz);
          check_field("out_vel_x", want.vx, got.vx);
          check_field("out_vel_y", want.vy, got.vy);
          check_field("out_vel_z", want.vz, got.vz);
          check_field("out_mass", want.mass, got.mass);
          check_field("target_alive", 32'(want.alive), 32'(got.alive));
        end
      end
      if (in_valid_i && !in_stall_o) begin
        op[0] = pos_x_i; op[1] = pos_y_i; op[2] = pos_z_i;
        ov[0] = vel_x_i; ov[1] = vel_y_i; ov[2] = vel_z_i;
        report_q.push_back(step_body(kind_i, op, ov, body_mass_i, other_alive_i, time_step_i));
      end
    end
    pending_o = report_q.size();
  end

  initial begin
    errors_o = 0;
    pending_o = 0;
  end

endmodule

// ----- tb/sv/tb_nbody_gravity_merge_integrate.sv -----
// Top of the gravity merge/integrate testbench: clock, reset, stimulus and verdict.
// Depends on nbgm_pkg, the block and nbgm_checker.
module tb_nbody_gravity_merge_integrate;
  import nbgm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_idx_i = CFG_GRAV;
  logic [31:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [2:0]         kind_i = KIND_CLEAR;
  logic signed [31:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic signed [31:0] vel_x_i = '0, vel_y_i = '0, vel_z_i = '0;
  logic [31:0]        body_mass_i = '0;
  logic               other_alive_i = 1'b0;
  logic [31:0]        time_step_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [1:0]         event_res_o;
  logic signed [31:0] out_pos_x_o, out_pos_y_o, out_pos_z_o;
  logic signed [31:0] out_vel_x_o, out_vel_y_o, out_vel_z_o;
  logic [31:0]        out_mass_o;
  logic               target_alive_o;
  int                 errors_o, pending_o;

  int  n_sent, n_recv, quiet_cycles;
  int  send_idle_pct, recv_stall_pct;
  int  kind_count[8];
  bit  sent_flag;
  logic signed [31:0] home[3];
  logic [31:0]        home_mass;

  nbody_gravity_merge_integrate i_dut (.*);
  nbgm_checker i_checker (.*);

  always #6 clk_i = ~clk_i;

  // Count transfers and watch for a hang
  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) n_sent <= n_sent + 1;
    if (out_valid_o && !out_stall_i) n_recv <= n_recv + 1;
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[nbody_gravity_merge_integrate] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver back-pressure
  always @(negedge clk_i) out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);

  task automatic set_regs(logic [31:0] g, logic [31:0] s, logic [31:0] m);
    @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= CFG_GRAV; cfg_data_i <= g;
    @(negedge clk_i);
    cfg_idx_i <= CFG_SOFT; cfg_data_i <= s;
    @(negedge clk_i);
    cfg_idx_i <= CFG_MERGE; cfg_data_i <= m;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Present one transfer and hold it until accepted
  task automatic send(logic [2:0] k, logic signed [31:0] px, logic signed [31:0] py,
                      logic signed [31:0] pz, logic signed [31:0] vx,
                      logic signed [31:0] vy, logic signed [31:0] vz,
                      logic [31:0] m, logic alive, logic [31:0] dt);
    @(negedge clk_i);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    kind_i <= k;
    pos_x_i <= px; pos_y_i <= py; pos_z_i <= pz;
    vel_x_i <= vx; vel_y_i <= vy; vel_z_i <= vz;
    body_mass_i <= m; other_alive_i <= alive; time_step_i <= dt;
    kind_count[k]++;
    if (k == KIND_LOAD) begin
      home[0] = px; home[1] = py; home[2] = pz; home_mass = m;
    end
    do begin
      @(posedge clk_i);
      sent_flag = in_valid_i && !in_stall_o;
    end while (!sent_flag);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (n_recv != n_sent || pending_o != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] near(logic signed [31:0] c);
    case ($urandom_range(0, 3))
      0: return c;
      1: return c + $signed($urandom_range(0, 32'h2000) - 32'h1000);
      2: return c + $signed($urandom_range(0, 32'h40000) - 32'h20000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_mass();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return home_mass;
      2: return 32'd0;
      default: return $urandom_range(1, 32'h0080_0000);
    endcase
  endfunction

  function automatic logic signed [31:0] pick_vel();
    return $urandom_range(0, 3) == 0 ? $signed($urandom)
                                     : $signed($urandom_range(0, 32'h80000) - 32'h40000);
  endfunction

  task automatic random_item();
    int sel;
    logic [2:0] k;
    sel = $urandom_range(0, 99);
    if (sel < 12) k = KIND_LOAD;
    else if (sel < 18) k = KIND_CLEAR;
    else if (sel < 56) k = KIND_PAIR;
    else if (sel < 76) k = KIND_POINT;
    else if (sel < 97) k = KIND_MOVE;
    else k = 3'($urandom_range(5, 7));
    if (k == KIND_LOAD && $urandom_range(0, 3) != 0) begin
      send(k, $signed($urandom_range(0, 32'h200000) - 32'h100000),
           $signed($urandom_range(0, 32'h200000) - 32'h100000),
           $signed($urandom_range(0, 32'h200000) - 32'h100000),
           pick_vel(), pick_vel(), pick_vel(), pick_mass(), $urandom, $urandom);
    end else begin
      send(k, near(home[0]), near(home[1]), near(home[2]),
           pick_vel(), pick_vel(), pick_vel(), pick_mass(),
           $urandom_range(0, 7) != 0,
           $urandom_range(0, 4) == 0 ? $urandom : $urandom_range(0, 32'h20000));
    end
  endtask

  initial begin
    logic [31:0] regs[6][3];
    n_sent = 0; n_recv = 0; quiet_cycles = 0;
    send_idle_pct = 27; recv_stall_pct = 70;
    home = '{0, 0, 0}; home_mass = 0;
    regs = '{'{32'h10000, 32'h4000, 32'h20000},
             '{32'h0, 32'h0, 32'h0},
             '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
             '{$urandom, 32'h10000, 32'h8000},
             '{32'h10000, 32'h0, 32'h40000},
             '{$urandom_range(0, 32'h100000), $urandom_range(0, 32'h20000),
               $urandom_range(0, 32'h40000)}};
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    set_regs(regs[0][0], regs[0][1], regs[0][2]);

    // Directed: dead target, extremes, zero distance, merges both ways, zero-mass move
    send(KIND_PAIR, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'h10000, 1'b1, 32'h0);
    send(KIND_POINT, 32'sd65536, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'hFFFF_FFFF,
         1'b0, 32'h0);
    send(KIND_LOAD, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
         32'sh7FFF_FFFF, 32'sh8000_0000, 32'hFFFF_FFFF, 1'b0, 32'h0);
    send(KIND_PAIR, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0, 32'sd0, 32'sd0,
         32'hFFFF_FFFF, 1'b1, 32'h0);
    send(KIND_MOVE, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'h0, 1'b0,
         32'hFFFF_FFFF);
    send(KIND_LOAD, 32'sd0, 32'sd0, 32'sd0, 32'sd65536, 32'sd0, -32'sd65536, 32'h30000,
         1'b1, 32'h0);
    send(KIND_PAIR, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'h10000, 1'b0, 32'h0);
    send(KIND_POINT, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'h10000, 1'b1, 32'h0);
    send(KIND_PAIR, 32'sd655360, -32'sd327680, 32'sd131072, 32'sd0, 32'sd0, 32'sd0,
         32'h50000, 1'b1, 32'h0);
    send(KIND_POINT, -32'sd655360, 32'sd65536, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'h20000,
         1'b1, 32'h0);
    send(KIND_MOVE, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'h0, 1'b0, 32'h10000);
    send(KIND_CLEAR, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'h0, 1'b0, 32'h0);
    send(KIND_MOVE, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'h0, 1'b0, 32'h8000);
    send(KIND_PAIR, 32'sd4096, 32'sd0, 32'sd0, 32'sd131072, 32'sd0, 32'sd0, 32'h10000,
         1'b1, 32'h0);
    send(KIND_PAIR, 32'sd4096, 32'sd4096, 32'sd0, 32'sd0, -32'sd131072, 32'sd0, 32'h80000,
         1'b1, 32'h0);
    send(KIND_PAIR, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'h10000, 1'b1, 32'h0);
    send(KIND_LOAD, 32'sd0, 32'sd0, 32'sd0, 32'sd65536, 32'sd65536, 32'sd0, 32'h40000,
         1'b1, 32'h0);
    send(KIND_PAIR, 32'sd0, 32'sd8192, 32'sd0, -32'sd65536, 32'sd0, 32'sd0, 32'h40000,
         1'b1, 32'h0);
    send(KIND_LOAD, 32'sd0, 32'sd0, 32'sd0, 32'sd65536, 32'sd0, 32'sd0, 32'h0, 1'b1, 32'h0);
    send(KIND_PAIR, 32'sd0, 32'sd0, 32'sd0, -32'sd65536, 32'sd0, 32'sd0, 32'h0, 1'b1, 32'h0);
    send(KIND_MOVE, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'h0, 1'b0, 32'h10000);
    send(3'd5, 32'sd1, 32'sd1, 32'sd1, 32'sd1, 32'sd1, 32'sd1, 32'h1, 1'b1, 32'h1);
    send(3'd6, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'h0, 1'b0, 32'h0);
    send(3'd7, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'h0, 1'b0, 32'h0);

    // Random phases, one register setting each; idling pattern changes every two
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        drain();
        set_regs(regs[ph][0], regs[ph][1], regs[ph][2]);
      end
      if (ph == 2) begin
        send_idle_pct = 70; recv_stall_pct = 27;
      end else if (ph == 4) begin
        send_idle_pct = 0; recv_stall_pct = 0;
      end
      repeat (72) random_item();
    end
    drain();

    $display("Sent %0d items (load %0d, clear %0d, pair %0d, point %0d, move %0d, other %0d)",
             n_sent, kind_count[KIND_LOAD], kind_count[KIND_CLEAR], kind_count[KIND_PAIR],
             kind_count[KIND_POINT], kind_count[KIND_MOVE],
             kind_count[5] + kind_count[6] + kind_count[7]);
    $display("Checked %0d results over 6 register settings and 3 idling patterns", n_recv);
    if (errors_o == 0 && pending_o == 0) begin
      $display("[nbody_gravity_merge_integrate] OK");
    end else begin
      $display("[nbody_gravity_merge_integrate] ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/nbgm_pkg.sv
rtl/nbgm_div.sv
rtl/nbgm_sqrt.sv
rtl/nbody_gravity_merge_integrate.sv
tb/sv/nbgm_checker.sv
tb/sv/tb_nbody_gravity_merge_integrate.sv
